// ===== hdl/sbcs_pkg.sv =====
// ============================================================================
// sbcs_pkg
// shared types, constants and window check functions for the block center
// selector
// ============================================================================
`default_nettype none

package sbcs_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 13;
    localparam int LIN_W   = 24;
    localparam int SZ_W    = 17;
    localparam int MIN_SIZE = 3;

    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);
    localparam logic             SELECT_RST = 1'b1;

    localparam logic [PIX_W-1:0] LSB_CLEAR = 8'hFE;
    localparam logic [PIX_W-1:0] LSB_SET   = 8'h01;

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_LAST  = 2'd2;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_SELECT_ENABLE = 2'd2
    } t_reg_idx;

    typedef logic [8:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic [LIN_W-1:0] pixel_index;
        logic [PIX_W-1:0] value;
    } t_result;

    typedef struct packed {
        logic             ok;
        logic [PIX_W-1:0] center;
    } t_win_status;

    // at most one equal pair among the six pairs of four pixels
    function automatic logic quad_ok(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d);
        logic [5:0] eq;
        eq = {a == b, a == c, a == d, b == c, b == d, c == d};
        return (eq & (eq - 6'd1)) == 6'd0;
    endfunction

    function automatic logic all_quads_ok(input t_window w, input logic [PIX_W-1:0] ctr);
        return quad_ok(w[0], w[1], w[3], ctr) &&
               quad_ok(w[1], w[2], ctr, w[5]) &&
               quad_ok(w[3], ctr, w[6], w[7]) &&
               quad_ok(ctr, w[5], w[7], w[8]);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/stego_block_center_selector_core.sv =====
// ============================================================================
// stego_block_center_selector_core
// grayscale 3x3 block center selector: row stores in one ram, sliding
// window, quadrant check and a small result queue
// ============================================================================
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------
//  pixel in | in        | i_in_valid / o_in_stall   | i_pixel_value
//  result   | out       | o_out_valid / i_out_stall | o_pixel_index, o_selected_value
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one pixel per cycle while o_in_stall is low; a pixel's result enters the queue
//  from stage 1 (registered ram read, window check on the read data)
//  both row stores share one ram word, read at the beat, written back the
//  next cycle; consecutive beats always address different columns
//  reset is synchronous; the row ram has no reset and no clearing pass
//  input stalls in reset and when the queue plus the pixel in flight could overflow
// ============================================================================
`default_nettype none

module stego_block_center_selector_core #(
    parameter int MAX_WIDTH  = sbcs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sbcs_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output      logic                         o_in_stall,
    input  wire logic [sbcs_pkg::PIX_W-1:0]   i_pixel_value,
    output      logic                         o_out_valid,
    input  wire logic                         i_out_stall,
    output      logic [sbcs_pkg::LIN_W-1:0]   o_pixel_index,
    output      logic [sbcs_pkg::PIX_W-1:0]   o_selected_value,
    input  wire logic                         i_cfg_valid,
    output      logic                         o_cfg_ready,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [sbcs_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int SZ_W = sbcs_pkg::SZ_W;
    localparam int PW   = sbcs_pkg::PIX_W;
    localparam int LW   = sbcs_pkg::LIN_W;

    // configuration
    logic [sbcs_pkg::CFG_W-1:0] r_image_width;
    logic [sbcs_pkg::CFG_W-1:0] r_image_height;
    logic                       r_select_enable;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= sbcs_pkg::WIDTH_RST;
            r_image_height  <= sbcs_pkg::HEIGHT_RST;
            r_select_enable <= sbcs_pkg::SELECT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (sbcs_pkg::t_reg_idx'(i_cfg_index))
                sbcs_pkg::REG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data;
                sbcs_pkg::REG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data;
                sbcs_pkg::REG_SELECT_ENABLE: r_select_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // effective geometry
    logic [SZ_W-1:0] w_raw;
    logic [SZ_W-1:0] h_raw;
    logic [SZ_W-1:0] w_eff;
    logic [SZ_W-1:0] h_eff;

    assign w_raw = {{(SZ_W-sbcs_pkg::CFG_W){1'b0}}, r_image_width};
    assign h_raw = {{(SZ_W-sbcs_pkg::CFG_W){1'b0}}, r_image_height};
    assign w_eff = (w_raw < SZ_W'(sbcs_pkg::MIN_SIZE)) ? SZ_W'(sbcs_pkg::MIN_SIZE) :
                   (w_raw > SZ_W'(MAX_WIDTH))          ? SZ_W'(MAX_WIDTH)          : w_raw;
    assign h_eff = (h_raw < SZ_W'(sbcs_pkg::MIN_SIZE)) ? SZ_W'(sbcs_pkg::MIN_SIZE) :
                   (h_raw > SZ_W'(MAX_HEIGHT))         ? SZ_W'(MAX_HEIGHT)         : h_raw;

    // queue occupancy and input handshake
    logic [sbcs_pkg::OQ_CW-1:0] q_count;
    logic [sbcs_pkg::OQ_CW:0]   occupancy;
    logic                       r_s1_valid;
    logic                       in_beat;

    assign occupancy  = {1'b0, q_count} + {{sbcs_pkg::OQ_CW{1'b0}}, r_s1_valid};
    assign o_in_stall = !i_rst_n || (occupancy > (sbcs_pkg::OQ_CW+1)'(sbcs_pkg::OQ_DEPTH - 1));
    assign in_beat    = i_in_valid && !o_in_stall;

    // position counters
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [1:0]      r_col_ph;
    logic [1:0]      r_row_ph;
    logic [LW-1:0]   r_lin;
    logic [SZ_W-1:0] col_ext;
    logic [SZ_W-1:0] row_ext;
    logic            col_last;
    logic            row_last;
    logic            center_pos;
    logic [LW-1:0]   center_idx;

    assign col_ext    = {{(SZ_W-CW){1'b0}}, r_col};
    assign row_ext    = {{(SZ_W-RW){1'b0}}, r_row};
    assign col_last   = (col_ext + SZ_W'(1)) >= w_eff;
    assign row_last   = (row_ext + SZ_W'(1)) >= h_eff;
    assign center_pos = (col_ext < w_eff) && (row_ext < h_eff) &&
                        (r_col_ph == sbcs_pkg::PH_LAST) && (r_row_ph == sbcs_pkg::PH_LAST);
    assign center_idx = r_lin - {{(LW-SZ_W){1'b0}}, w_eff} - LW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= sbcs_pkg::PH_FIRST;
            r_row_ph <= sbcs_pkg::PH_FIRST;
            r_lin    <= '0;
        end else if (in_beat) begin
            if (col_last) begin
                r_col    <= '0;
                r_col_ph <= sbcs_pkg::PH_FIRST;
                if (row_last) begin
                    r_row    <= '0;
                    r_row_ph <= sbcs_pkg::PH_FIRST;
                    r_lin    <= '0;
                end else begin
                    r_row    <= r_row + 1'b1;
                    r_row_ph <= (r_row_ph == sbcs_pkg::PH_LAST) ? sbcs_pkg::PH_FIRST
                                                               : r_row_ph + 2'd1;
                    r_lin    <= r_lin + 1'b1;
                end
            end else begin
                r_col    <= r_col + 1'b1;
                r_col_ph <= (r_col_ph == sbcs_pkg::PH_LAST) ? sbcs_pkg::PH_FIRST
                                                           : r_col_ph + 2'd1;
                r_lin    <= r_lin + 1'b1;
            end
        end
    end

    // stage 1: ram data valid, window shift, write back
    logic [CW-1:0] r_s1_slot;
    logic [PW-1:0] r_s1_px;
    logic [LW-1:0] r_s1_idx;
    logic          r_s1_pass;
    logic          r_s1_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_slot   <= r_col;
            r_s1_px     <= i_pixel_value;
            r_s1_idx    <= r_select_enable ? center_idx : r_lin;
            r_s1_pass   <= !r_select_enable;
            r_s1_center <= center_pos;
        end
    end

    logic [2*PW-1:0] rows_rd;
    logic [PW-1:0]   up_px;
    logic [PW-1:0]   mid_px;

    assign up_px  = rows_rd[2*PW-1:PW];
    assign mid_px = rows_rd[PW-1:0];

    sbcs_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .i_clk     (i_clk),
        .i_rd_en   (in_beat),
        .i_rd_addr (r_col),
        .o_rd_data (rows_rd),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_slot),
        .i_wr_data ({mid_px, r_s1_px})
    );

    sbcs_pkg::t_win_status win_status;

    sbcs_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (r_s1_valid),
        .i_up     (up_px),
        .i_mid    (mid_px),
        .i_px     (r_s1_px),
        .o_status (win_status)
    );

    // result queue
    logic              q_push;
    sbcs_pkg::t_result q_in;
    sbcs_pkg::t_result q_out;

    assign q_push = r_s1_valid && (r_s1_pass || (r_s1_center && win_status.ok));
    assign q_in.pixel_index = r_s1_idx;
    assign q_in.value       = r_s1_pass ? r_s1_px : win_status.center;

    sbcs_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (q_out),
        .o_count (q_count)
    );

    assign o_pixel_index    = q_out.pixel_index;
    assign o_selected_value = q_out.value;

    // checks
    a_no_same_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && in_beat) |-> (r_s1_slot != r_col))
        else $error("row ram read and write hit the same column");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= (sbcs_pkg::OQ_CW+1)'(sbcs_pkg::OQ_DEPTH))
        else $error("result queue overflow");

    a_phase_follows_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col == '0) |-> (r_col_ph == sbcs_pkg::PH_FIRST))
        else $error("column phase out of step");

    a_select_needs_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !r_s1_pass) |-> r_s1_center)
        else $error("center emitted off a block center");

endmodule

`default_nettype wire

// ===== hdl/sbcs_ram.sv =====
// ============================================================================
// sbcs_ram
// generic single-clock ram, one write port and one registered read port
// ============================================================================
`default_nettype none

module sbcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/sbcs_window.sv =====
// ============================================================================
// sbcs_window
// 3x3 pixel window and the quadrant check on its center
// ============================================================================
`default_nettype none

module sbcs_window (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_shift,
    input  wire logic [sbcs_pkg::PIX_W-1:0] i_up,
    input  wire logic [sbcs_pkg::PIX_W-1:0] i_mid,
    input  wire logic [sbcs_pkg::PIX_W-1:0] i_px,
    output      sbcs_pkg::t_win_status    o_status
);

    sbcs_pkg::t_window r_win;
    sbcs_pkg::t_window n_win;
    logic [sbcs_pkg::PIX_W-1:0] c0;
    logic [sbcs_pkg::PIX_W-1:0] c1;

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = i_up;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = i_mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = i_px;
    end

    assign c0 = n_win[4] & sbcs_pkg::LSB_CLEAR;
    assign c1 = c0 | sbcs_pkg::LSB_SET;

    assign o_status.ok     = sbcs_pkg::all_quads_ok(n_win, c0) &&
                             sbcs_pkg::all_quads_ok(n_win, c1);
    assign o_status.center = n_win[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_shift) begin
            r_win <= n_win;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sbcs_out_q.sv =====
// ============================================================================
// sbcs_out_q
// small result queue in front of the output channel
// ============================================================================
`default_nettype none

module sbcs_out_q (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire sbcs_pkg::t_result          i_data,
    input  wire logic                       i_stall,
    output      logic                       o_valid,
    output      sbcs_pkg::t_result          o_data,
    output      logic [sbcs_pkg::OQ_CW-1:0] o_count
);

    function automatic logic [sbcs_pkg::OQ_CW-1:0] OQ_CW_ONE(input logic b);
        return {{(sbcs_pkg::OQ_CW-1){1'b0}}, b};
    endfunction

    sbcs_pkg::t_result          r_mem [sbcs_pkg::OQ_DEPTH];
    logic [sbcs_pkg::OQ_AW-1:0] r_wr_ptr;
    logic [sbcs_pkg::OQ_AW-1:0] r_rd_ptr;
    logic [sbcs_pkg::OQ_CW-1:0] r_count;
    logic                       pop;

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + OQ_CW_ONE(i_push) - OQ_CW_ONE(pop);
        end
    end

endmodule

`default_nettype wire

// ===== verif/stego_block_center_selector_core_tb.sv =====
// ============================================================================
// stego_block_center_selector_core_tb
// self-checking bench for the 3x3 block center selector: a cycle-free
// software copy of the selector predicts every emitted pixel, and each result
// beat is compared field by field in order; directed frames cover size
// clamping, the quadrant rules, mid-frame geometry changes and pass-through,
// then random frames run under random input gaps and output stalls
// ============================================================================

module stego_block_center_selector_core_tb;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 120;
    localparam int          RANDOM_PIXELS = 1800;
    localparam int unsigned MAX_W         = sbcs_pkg::MAX_WIDTH_DEF;
    localparam int unsigned MAX_H         = sbcs_pkg::MAX_HEIGHT_DEF;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            in_valid    = 1'b0;
    logic                            in_stall;
    logic [sbcs_pkg::PIX_W-1:0]      pixel_value = '0;
    logic                            out_valid;
    logic                            out_stall   = 1'b0;
    logic [sbcs_pkg::LIN_W-1:0]      out_index;
    logic [sbcs_pkg::PIX_W-1:0]      out_value;
    logic                            cfg_valid   = 1'b0;
    logic                            cfg_ready;
    logic [1:0]                      cfg_index   = '0;
    logic [sbcs_pkg::CFG_W-1:0]      cfg_data    = '0;

    // selector copy: registers, row stores, window and position counters
    logic [sbcs_pkg::CFG_W-1:0]      reg_width   = sbcs_pkg::CFG_W'(640);
    logic [sbcs_pkg::CFG_W-1:0]      reg_height  = sbcs_pkg::CFG_W'(480);
    logic                            reg_select  = 1'b1;
    logic [sbcs_pkg::PIX_W-1:0]      upper_line [MAX_W] = '{default: '0};
    logic [sbcs_pkg::PIX_W-1:0]      middle_line [MAX_W] = '{default: '0};
    logic [sbcs_pkg::PIX_W-1:0]      win_px [9] = '{default: '0};
    int unsigned                     at_col = 0;
    int unsigned                     at_row = 0;
    logic [sbcs_pkg::LIN_W-1:0]      at_pos = '0;

    sbcs_pkg::t_result               emitted_pixels [$];
    int                              err_count   = 0;
    int                              pixels_sent = 0;
    int                              burst_left  = 0;
    bit                              hold_req    = 1'b0;

    stego_block_center_selector_core u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_pixel_value    (pixel_value),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_pixel_index    (out_index),
        .o_selected_value (out_value),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    initial begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic int unsigned size_limit(input logic [sbcs_pkg::CFG_W-1:0] v,
                                               input int unsigned hi);
        if (v < sbcs_pkg::MIN_SIZE) return sbcs_pkg::MIN_SIZE;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic bit quad_unique(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
        int n;
        n = int'(a == b) + int'(a == c) + int'(a == d) + int'(b == c) + int'(b == d)
            + int'(c == d);
        return n <= 1;
    endfunction

    function automatic bit center_fits(input logic [7:0] ctr);
        return quad_unique(win_px[0], win_px[1], win_px[3], ctr) &&
               quad_unique(win_px[1], win_px[2], ctr, win_px[5]) &&
               quad_unique(win_px[3], ctr, win_px[6], win_px[7]) &&
               quad_unique(ctr, win_px[5], win_px[7], win_px[8]);
    endfunction

    // one accepted pixel: update stores and window, queue the pixel it emits
    function automatic void scan_pixel(input logic [sbcs_pkg::PIX_W-1:0] px);
        int unsigned       w;
        int unsigned       h;
        int unsigned       slot;
        logic [7:0]        up_px;
        logic [7:0]        mid_px;
        logic [7:0]        ctr_lo;
        logic [7:0]        ctr_hi;
        sbcs_pkg::t_result hit;
        w = size_limit(reg_width, MAX_W);
        h = size_limit(reg_height, MAX_H);
        slot = (at_col < MAX_W) ? at_col : MAX_W - 1;
        up_px = upper_line[slot];
        mid_px = middle_line[slot];
        upper_line[slot] = mid_px;
        middle_line[slot] = px;
        win_px[0] = win_px[1]; win_px[1] = win_px[2]; win_px[2] = up_px;
        win_px[3] = win_px[4]; win_px[4] = win_px[5]; win_px[5] = mid_px;
        win_px[6] = win_px[7]; win_px[7] = win_px[8]; win_px[8] = px;
        if (reg_select) begin
            if (at_col < w && at_row < h && at_col % 3 == 2 && at_row % 3 == 2) begin
                ctr_lo = win_px[4] & sbcs_pkg::LSB_CLEAR;
                ctr_hi = ctr_lo | sbcs_pkg::LSB_SET;
                if (center_fits(ctr_lo) && center_fits(ctr_hi)) begin
                    hit.pixel_index = at_pos - sbcs_pkg::LIN_W'(w) - 24'd1;
                    hit.value = win_px[4];
                    emitted_pixels.push_back(hit);
                end
            end
        end else begin
            hit.pixel_index = at_pos;
            hit.value = px;
            emitted_pixels.push_back(hit);
        end
        if (at_col + 1 >= w) begin
            at_col = 0;
            if (at_row + 1 >= h) begin
                at_row = 0;
                at_pos = '0;
            end else begin
                at_row = at_row + 1;
                at_pos = at_pos + 24'd1;
            end
        end else begin
            at_col = at_col + 1;
            at_pos = at_pos + 24'd1;
        end
    endfunction

    function automatic logic [7:0] draw_pixel(input int style);
        case (style)
            1: return 8'($urandom_range(0, 3));
            2: return 8'($urandom_range(100, 103));
            3: return $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one pixel beat, with bursts and random gaps between them
    task automatic send_pixel(input logic [sbcs_pkg::PIX_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        pixel_value <= value;
        do @(posedge clk); while (in_stall);
        pixels_sent++;
        scan_pixel(value);
    endtask

    task automatic run_to_frame_end(input int style);
        do send_pixel(draw_pixel(style)); while (at_col != 0 || at_row != 0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (emitted_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input sbcs_pkg::t_reg_idx idx,
                             input logic [sbcs_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            sbcs_pkg::REG_IMAGE_WIDTH:   reg_width = value;
            sbcs_pkg::REG_IMAGE_HEIGHT:  reg_height = value;
            sbcs_pkg::REG_SELECT_ENABLE: reg_select = value[0];
            default: ;
        endcase
    endtask

    task automatic program_frame(input logic [sbcs_pkg::CFG_W-1:0] width,
                                 input logic [sbcs_pkg::CFG_W-1:0] height, input bit sel);
        wait_idle();
        write_reg(sbcs_pkg::REG_IMAGE_WIDTH, width);
        write_reg(sbcs_pkg::REG_IMAGE_HEIGHT, height);
        write_reg(sbcs_pkg::REG_SELECT_ENABLE, sbcs_pkg::CFG_W'(sel));
        cfg_valid <= 1'b0;
    endtask

    // defaults select centers, so a few pixels emit nothing; then pass-through
    task automatic test_reset_state();
        repeat (6) send_pixel(draw_pixel(0));
        program_frame(13'd640, 13'd480, 1'b0);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        repeat (6) send_pixel(draw_pixel(0));
    endtask

    // full pass-through frame as wide as the widest random frame
    task automatic test_wide_frame();
        program_frame(13'd48, 13'd3, 1'b0);
        run_to_frame_end(0);
    endtask

    // width above the maximum takes effect right before a center, so its
    // index counts back by the clamped width
    task automatic test_width_clamp();
        logic [7:0] lead_px [8];
        lead_px = '{8'd10, 8'd20, 8'd30, 8'd40, 8'd51, 8'd60, 8'd70, 8'd80};
        program_frame(13'd3, 13'd9, 1'b1);
        foreach (lead_px[k]) send_pixel(lead_px[k]);
        program_frame(13'h1FFF, 13'd9, 1'b1);
        send_pixel(8'd90);
        program_frame(13'd3, 13'd9, 1'b1);
        run_to_frame_end(0);
    endtask

    // both sizes below the minimum, then a height above the maximum
    task automatic test_height_clamp();
        program_frame(13'd0, 13'd2, 1'b1);
        run_to_frame_end(0);
        program_frame(13'd3, 13'h1FFF, 1'b1);
        repeat (30) send_pixel(draw_pixel(1));
        program_frame(13'd3, 13'd3, 1'b1);
        run_to_frame_end(0);
    endtask

    // first block all distinct, second fails only with the center low bit set
    task automatic test_quadrant_rules();
        logic [7:0] frame_px [18];
        frame_px = '{8'd0,  8'd10, 8'd20,  8'd7,   8'd51,  8'd90,
                     8'd30, 8'd41, 8'd60,  8'd7,   8'd50,  8'd100,
                     8'd70, 8'd80, 8'd255, 8'd110, 8'd120, 8'd130};
        program_frame(13'd6, 13'd3, 1'b1);
        foreach (frame_px[k]) send_pixel(frame_px[k]);
    endtask

    // width grows just before a center, so its index wraps below zero;
    // then both sizes shrink so the next center column lies outside
    task automatic test_midframe_geometry();
        logic [7:0] lead_px [8];
        lead_px = '{8'd10, 8'd20, 8'd30, 8'd40, 8'd51, 8'd60, 8'd70, 8'd80};
        program_frame(13'd3, 13'd9, 1'b1);
        foreach (lead_px[k]) send_pixel(lead_px[k]);
        program_frame(13'd9, 13'd9, 1'b1);
        send_pixel(8'd90);
        repeat (2) send_pixel(draw_pixel(0));
        program_frame(13'd4, 13'd5, 1'b1);
        send_pixel(draw_pixel(0));
        run_to_frame_end(0);
    endtask

    // long output hold-off while pixels keep coming, so the input backs up
    task automatic test_output_hold_off();
        program_frame(13'd5, 13'd4, 1'b0);
        hold_req = 1'b1;
        repeat (40) send_pixel(draw_pixel(0));
    endtask

    task automatic test_random_frames();
        logic [sbcs_pkg::CFG_W-1:0] w;
        logic [sbcs_pkg::CFG_W-1:0] h;
        bit                         sel;
        int                         style;
        int unsigned                area;
        int                         start;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0: w = sbcs_pkg::CFG_W'($urandom_range(0, 2));
                1: w = sbcs_pkg::CFG_W'($urandom_range(13, 48));
                default: w = sbcs_pkg::CFG_W'($urandom_range(3, 12));
            endcase
            h = ($urandom_range(0, 9) == 0) ? sbcs_pkg::CFG_W'($urandom_range(0, 2))
                                            : sbcs_pkg::CFG_W'($urandom_range(3, 12));
            sel = ($urandom_range(0, 3) != 0);
            style = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 3);
            program_frame(w, h, sel);
            area = size_limit(w, MAX_W) * size_limit(h, MAX_H);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2 * area)) send_pixel(draw_pixel(style));
            end else begin
                run_to_frame_end(style);
                repeat (area * $urandom_range(0, 1)) send_pixel(draw_pixel(style));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_wide_frame();
        test_width_clamp();
        test_height_clamp();
        test_quadrant_rules();
        test_midframe_geometry();
        test_output_hold_off();
        test_random_frames();
        wait_idle();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : out_stall_pattern
        int span;
        int busy_pct;
        forever begin
            if (hold_req) begin
                repeat (HOLD_CYCLES) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
                hold_req = 1'b0;
            end else begin
                span = $urandom_range(4, 48);
                busy_pct = 25 * $urandom_range(0, 3);
                for (int k = 0; k < span && !hold_req; k++) begin
                    out_stall <= ($urandom_range(0, 99) < busy_pct);
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin : result_check
        sbcs_pkg::t_result due;
        if (rst_n && out_valid && !out_stall) begin
            if (emitted_pixels.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing due: index %0d value %0d",
                                        out_index, out_value));
            end else begin
                due = emitted_pixels.pop_front();
                if (out_index !== due.pixel_index) begin
                    flag_mismatch($sformatf("pixel_index %0d, want %0d", out_index,
                                            due.pixel_index));
                end
                if (out_value !== due.value) begin
                    flag_mismatch($sformatf("selected_value %0d at index %0d, want %0d",
                                            out_value, due.pixel_index, due.value));
                end
            end
        end
    end

endmodule
